// ----- src/ckb_pkg.sv -----
// Shared types, codes and helpers for the circular kernel blur block.
package ckb_pkg;

  // Fixed field widths.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TAPIDX_W  = 6;
  localparam int unsigned TAPWT_W   = 13;
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 8;
  localparam int unsigned KSIZE_W   = 3;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  // Signed window position: covers coordinate plus offset and 2*dim - pos.
  localparam int unsigned POS_W     = 11;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_WRITE_PIXEL = 2'd1,
    OP_FILTER      = 2'd2,
    OP_NONE        = 2'd3
  } ckb_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_RES_SHIFT    = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } ckb_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } ckb_state_e;

  // Symmetric reflection into [0, n), then clamp for tiny images.
  function automatic logic [DIM_W-1:0] ckb_reflect(input logic signed [POS_W-1:0] pos,
                                                   input logic [DIM_W-1:0] n);
    logic signed [POS_W-1:0] ns;
    logic signed [POS_W-1:0] r;
    ns = signed'(POS_W'(n));
    if (pos < 0) begin
      r = -pos - POS_W'(1);
    end else if (pos >= ns) begin
      r = (ns <<< 1) - pos - POS_W'(1);
    end else begin
      r = pos;
    end
    if (r < 0) begin
      r = '0;
    end
    if (r >= ns) begin
      r = ns - POS_W'(1);
    end
    return r[DIM_W-1:0];
  endfunction

endpackage

// ----- src/circular_kernel_blur.sv -----
// Circular kernel blur: frame store, weight table and tap-serial convolution.
// Weight load and pixel write take effect in the accept cycle; a filter request yields
//   its beat once all k*k taps have been accumulated (k = effective size).
// Throughput: one item at a time; a filter request holds the input until its beat is
//   registered; taps are read through the single frame store read port, one tap per cycle.
// Reset: control and config return to defaults (size 3, shift 10, 128x128);
//   frame store and weight table stay undefined until written, no clearing pass.
module circular_kernel_blur
  import ckb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 128,
  parameter int unsigned MAX_HEIGHT  = 128,
  parameter int unsigned MAX_KERNEL  = 7,
  parameter int unsigned WEIGHT_BITS = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [TAPIDX_W-1:0]  tap_index_i,
  input  logic [TAPWT_W-1:0]   tap_weight_i,
  input  logic [COORD_W-1:0]   pixel_row_i,
  input  logic [COORD_W-1:0]   pixel_col_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     blurred_pixel_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COORD_W-1:0]   out_col_o
);

  localparam int unsigned TAPS   = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned TW     = $clog2(TAPS);
  localparam int unsigned AW     = $clog2(PIXELS);
  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1);
  localparam int unsigned PROD_W = WEIGHT_BITS + PIX_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KSIZE_W-1:0] ksize_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [DIM_W-1:0]   width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q  <= KSIZE_W'(3);
      shift_q  <= SHIFT_W'(10);
      width_q  <= DIM_W'(128);
      height_q <= DIM_W'(128);
    end else if (cfg_we_i) begin
      case (ckb_cfg_e'(cfg_idx_i))
        CFG_KERNEL_SIZE:  ksize_q  <= cfg_wdata_i[KSIZE_W-1:0];
        CFG_RES_SHIFT:    shift_q  <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective kernel size and image dimensions, sampled when a request starts.
  logic [31:0]      k_eff, w_eff, h_eff;
  logic [DIM_W-1:0] w_new, h_new;
  logic [KW-1:0]    k_new;

  always_comb begin
    k_eff = 32'({ksize_q[KSIZE_W-1:1], 1'b1});
    if (k_eff > MAX_KERNEL) begin
      k_eff = MAX_KERNEL;
    end
    w_eff = 32'(width_q);
    if (w_eff == 32'd0) begin
      w_eff = 32'd1;
    end else if (w_eff > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end
    h_eff = 32'(height_q);
    if (h_eff == 32'd0) begin
      h_eff = 32'd1;
    end else if (h_eff > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end
    k_new = k_eff[KW-1:0];
    w_new = w_eff[DIM_W-1:0];
    h_new = h_eff[DIM_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic        in_fire;
  logic        load_weight, write_pixel, req_ok, start;
  logic [31:0] tap_ext, wt_ext, wr_addr_ext;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    tap_ext     = 32'(tap_index_i);
    wt_ext      = 32'(tap_weight_i);
    wr_addr_ext = 32'(pixel_row_i) * MAX_WIDTH + 32'(pixel_col_i);
    load_weight = in_fire && (ckb_op_e'(op_i) == OP_LOAD_WEIGHT) && (tap_ext < TAPS);
    write_pixel = in_fire && (ckb_op_e'(op_i) == OP_WRITE_PIXEL)
                  && (32'(pixel_row_i) < MAX_HEIGHT) && (32'(pixel_col_i) < MAX_WIDTH);
    // Requests outside the current image produce no beat; drop them.
    req_ok      = (32'(pixel_row_i) < h_eff) && (32'(pixel_col_i) < w_eff);
    start       = in_fire && (ckb_op_e'(op_i) == OP_FILTER) && req_ok;
  end

  // ---------------------------------------------------------------------------
  // Request context and tap counters
  // ---------------------------------------------------------------------------
  logic [KW-1:0]      k_q, a_q, b_q;
  logic [TW-1:0]      tap_q;
  logic [DIM_W-1:0]   w_q, h_q;
  logic [COORD_W-1:0] req_row_q, req_col_q;
  logic               last_tap;

  ckb_state_e state_q, state_d;
  logic       issue, finish, drained;

  assign last_tap = (a_q == k_q - KW'(1)) && (b_q == k_q - KW'(1));

  always_ff @(posedge clk_i) begin
    if (start) begin
      k_q       <= k_new;
      w_q       <= w_new;
      h_q       <= h_new;
      req_row_q <= pixel_row_i;
      req_col_q <= pixel_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      b_q   <= '0;
      tap_q <= '0;
    end else if (start) begin
      a_q   <= '0;
      b_q   <= '0;
      tap_q <= '0;
    end else if (issue) begin
      // Advance column first, then row; tap index runs row-major.
      tap_q <= tap_q + TW'(1);
      if (b_q == k_q - KW'(1)) begin
        b_q <= '0;
        a_q <= a_q + KW'(1);
      end else begin
        b_q <= b_q + KW'(1);
      end
    end
  end

  // Window position for tap (a, b): true convolution, so offsets are mirrored.
  logic signed [POS_W-1:0] y_pos, x_pos;
  logic [DIM_W-1:0]        y_idx, x_idx;
  logic [31:0]             rd_addr_ext;

  always_comb begin
    y_pos = signed'(POS_W'(req_row_q)) + signed'(POS_W'(k_q >> 1)) - signed'(POS_W'(a_q));
    x_pos = signed'(POS_W'(req_col_q)) + signed'(POS_W'(k_q >> 1)) - signed'(POS_W'(b_q));
    y_idx = ckb_reflect(y_pos, h_q);
    x_idx = ckb_reflect(x_pos, w_q);
    rd_addr_ext = 32'(y_idx) * MAX_WIDTH + 32'(x_idx);
  end

  // ---------------------------------------------------------------------------
  // Memories: one write port, one registered read port each
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]       frame_mem [PIXELS];
  logic [WEIGHT_BITS-1:0] weight_mem [TAPS];
  logic [PIX_W-1:0]       pix_rd_q;
  logic [WEIGHT_BITS-1:0] wt_rd_q;

  always_ff @(posedge clk_i) begin
    if (write_pixel) begin
      frame_mem[wr_addr_ext[AW-1:0]] <= pixel_in_i;
    end
    pix_rd_q <= frame_mem[rd_addr_ext[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load_weight) begin
      weight_mem[tap_ext[TW-1:0]] <= wt_ext[WEIGHT_BITS-1:0];
    end
    wt_rd_q <= weight_mem[tap_q];
  end

  // ---------------------------------------------------------------------------
  // Multiply-accumulate pipeline: read -> product -> accumulate
  // ---------------------------------------------------------------------------
  logic              rd_vld_q, prod_vld_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(wt_rd_q) * PROD_W'(pix_rd_q);
    if (start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign drained = !rd_vld_q && !prod_vld_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_RUN;
      ST_RUN:    if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN:  if (drained) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_RUN:    issue      = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: finish     = !out_valid_o || out_ready_i;
      default:   ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: scale, saturate, hold until taken
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] scaled;
  logic [PIX_W-1:0] sat;
  logic             out_valid_q;
  logic [PIX_W-1:0] blurred_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;

  always_comb begin
    scaled = acc_q >> shift_q;
    sat    = (scaled > ACC_W'(255)) ? PIX_W'(255) : scaled[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      blurred_q <= sat;
      out_row_q <= req_row_q;
      out_col_q <= req_col_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_pixel_o = blurred_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;

endmodule
